FILE: sv/rmq_pkg.sv
// Shared types and constants for the rotation-matrix-to-quaternion pipeline.
// No dependencies; every other file imports this package.
`default_nettype none
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DATA_W        = 16;
    localparam int NUM_W         = DATA_W + 1;
    localparam int N_IN          = 9;
    localparam int N_OUT         = 4;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } branch_t;

    typedef struct packed {
        branch_t                     br;
        logic [2:0][NUM_W-1:0]       num;
    } side_t;

endpackage
`default_nettype wire

FILE: sv/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion, fully pipelined.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div and rmq_back.
//
//   Channel   Ports                    Payload
//   input     s_tvalid/s_tready/s_tdata   r0c0..r2c2, 9 x 16 bits
//   result    m_tvalid/m_tready/m_tdata   quat_w..quat_z, 4 x 16 bits
//
// One transfer is accepted per cycle while the output register is empty or
// being drained. Items pass the front register, the one-bit-per-stage square
// root, the one-bit-per-stage dividers and the output register; all stages
// advance together under that condition, so a stall holds every item.
// Reset clears the valid bits only.
`default_nettype none
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 from bit 0 up
    input  wire logic [N_IN*DATA_W-1:0]     s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up
    output logic [N_OUT*DATA_W-1:0]         m_tdata
);

    localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int RW = (AW + FRAC_BITS) / 2;

    logic                      ce;
    logic                      f_valid, r_valid, d_valid;
    logic [AW-2:0]             f_arg;
    side_t                     f_side, r_side;
    logic [RW-1:0]             r_root, d_big;
    branch_t                   d_br;
    logic [2:0][FRAC_BITS:0]   d_q;
    logic [2:0]                d_ovf, d_neg;
    logic                      d_zero;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    rmq_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_tvalid), .in_data(s_tdata),
        .out_valid(f_valid), .out_arg(f_arg), .out_side(f_side)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .AW(AW), .RW(RW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(f_valid), .in_arg(f_arg), .in_side(f_side),
        .out_valid(r_valid), .out_root(r_root), .out_side(r_side)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(r_valid), .in_root(r_root), .in_side(r_side),
        .out_valid(d_valid), .out_br(d_br), .out_big(d_big), .out_q(d_q),
        .out_ovf(d_ovf), .out_neg(d_neg), .out_zero(d_zero)
    );

    rmq_back #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(d_valid), .in_br(d_br), .in_big(d_big), .in_q(d_q),
        .in_ovf(d_ovf), .in_neg(d_neg), .in_zero(d_zero),
        .out_valid(m_tvalid), .out_data(m_tdata)
    );

endmodule
`default_nettype wire

FILE: sv/rmq_front.sv
// Input stage: branch selection, square-root argument and numerators.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int AW        = 20
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     ce,
    input  wire logic                     in_valid,
    input  wire logic [N_IN*DATA_W-1:0]   in_data,
    output logic                          out_valid,
    output logic [AW-2:0]                 out_arg,
    output side_t                         out_side
);

    logic signed [AW-1:0]     e [N_IN];
    logic signed [AW-1:0]     one_c;
    logic signed [AW-1:0]     trace;
    logic signed [AW-1:0]     arg;
    logic signed [NUM_W-1:0]  d_wx, d_y, d_z, s_xy, s_xz, s_yz;
    logic                     vld_reg;
    logic [AW-2:0]            arg_reg, arg_next;
    side_t                    side_reg, side_next;

    always_comb begin
        for (int i = 0; i < N_IN; i++) begin
            e[i] = AW'($signed(in_data[i*DATA_W +: DATA_W]));
        end
    end

    assign one_c = AW'(1) <<< FRAC_BITS;
    assign trace = e[0] + e[4] + e[8];
    assign d_wx  = NUM_W'($signed(in_data[7*DATA_W +: DATA_W]))
                 - NUM_W'($signed(in_data[5*DATA_W +: DATA_W]));
    assign d_y   = NUM_W'($signed(in_data[2*DATA_W +: DATA_W]))
                 - NUM_W'($signed(in_data[6*DATA_W +: DATA_W]));
    assign d_z   = NUM_W'($signed(in_data[3*DATA_W +: DATA_W]))
                 - NUM_W'($signed(in_data[1*DATA_W +: DATA_W]));
    assign s_xy  = NUM_W'($signed(in_data[1*DATA_W +: DATA_W]))
                 + NUM_W'($signed(in_data[3*DATA_W +: DATA_W]));
    assign s_xz  = NUM_W'($signed(in_data[2*DATA_W +: DATA_W]))
                 + NUM_W'($signed(in_data[6*DATA_W +: DATA_W]));
    assign s_yz  = NUM_W'($signed(in_data[5*DATA_W +: DATA_W]))
                 + NUM_W'($signed(in_data[7*DATA_W +: DATA_W]));

    always_comb begin
        if (trace > 0) begin
            side_next.br = BR_W;
            arg          = trace + one_c;
            side_next.num = {d_z, d_y, d_wx};
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            side_next.br = BR_X;
            arg          = one_c + e[0] - e[4] - e[8];
            side_next.num = {s_xz, s_xy, d_wx};
        end else if (e[4] > e[8]) begin
            side_next.br = BR_Y;
            arg          = one_c + e[4] - e[0] - e[8];
            side_next.num = {s_yz, s_xy, d_y};
        end else begin
            side_next.br = BR_Z;
            arg          = one_c + e[8] - e[0] - e[4];
            side_next.num = {s_yz, s_xz, d_z};
        end
        arg_next = arg[AW-1] ? '0 : arg[AW-2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            arg_reg  <= arg_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_arg   = arg_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

FILE: sv/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int AW        = 20,
    parameter int RW        = 17
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ce,
    input  wire logic            in_valid,
    input  wire logic [AW-2:0]   in_arg,
    input  wire side_t           in_side,
    output logic                 out_valid,
    output logic [RW-1:0]        out_root,
    output side_t                out_side
);

    localparam int VW    = 2 * RW;
    localparam int REM_W = RW + 3;

    logic             vld_reg  [RW];
    logic [REM_W-1:0] rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [VW-1:0]    v_reg    [RW];
    side_t            side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic             vld_src;
        logic [REM_W-1:0] rem_src, cat, trial, rem_next;
        logic [RW-1:0]    root_src, root_next;
        logic [VW-1:0]    v_src;
        side_t            side_src;

        if (k == 0) begin : g_first
            assign vld_src  = in_valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign v_src    = VW'(in_arg) << FRAC_BITS;
            assign side_src = in_side;
        end else begin : g_next
            assign vld_src  = vld_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign v_src    = v_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        assign cat   = {rem_src[REM_W-3:0], v_src[VW-1-2*k -: 2]};
        assign trial = REM_W'({root_src, 2'b01});

        always_comb begin
            if (cat >= trial) begin
                rem_next  = cat - trial;
                root_next = {root_src[RW-2:0], 1'b1};
            end else begin
                rem_next  = cat;
                root_next = {root_src[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                v_reg[k]    <= v_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule
`default_nettype wire

FILE: sv/rmq_div.sv
// Three-lane pipelined restoring divider: n / (2 * root), rounded to nearest.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int RW        = 17
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        ce,
    input  wire logic                        in_valid,
    input  wire logic [RW-1:0]               in_root,
    input  wire side_t                       in_side,
    output logic                             out_valid,
    output branch_t                          out_br,
    output logic [RW-1:0]                    out_big,
    output logic [2:0][FRAC_BITS:0]          out_q,
    output logic [2:0]                       out_ovf,
    output logic [2:0]                       out_neg,
    output logic                             out_zero
);

    localparam int QW  = FRAC_BITS + 1;
    localparam int DDW = NUM_W + FRAC_BITS + 1;
    localparam int SHW = RW + FRAC_BITS + 2;
    localparam int CW  = ((DDW > SHW) ? DDW : SHW) + 1;

    logic                  s_vld_reg;
    logic [2:0][CW-1:0]    s_dvd_reg, s_dvd_next;
    logic [CW-1:0]         s_dvs_reg, s_dvs_next;
    logic [2:0]            s_ovf_reg, s_ovf_next, s_neg_reg, s_neg_next;
    logic                  s_zero_reg;
    branch_t               s_br_reg;
    logic [RW-1:0]         s_big_reg, s_big_next;

    logic                  vld_reg  [QW];
    logic [2:0][CW-1:0]    rem_reg  [QW];
    logic [2:0][QW-1:0]    q_reg    [QW];
    logic [CW-1:0]         dvs_reg  [QW];
    logic [2:0]            ovf_reg  [QW];
    logic [2:0]            neg_reg  [QW];
    logic                  zero_reg [QW];
    branch_t               br_reg   [QW];
    logic [RW-1:0]         big_reg  [QW];

    always_comb begin
        logic [NUM_W-1:0] n, mag;
        s_dvs_next = CW'({in_root, 1'b0});
        s_big_next = RW'((RW+1)'(in_root) + (RW+1)'(1) >> 1);
        for (int l = 0; l < 3; l++) begin
            n              = in_side.num[l];
            s_neg_next[l]  = n[NUM_W-1];
            mag            = n[NUM_W-1] ? NUM_W'(-n) : n;
            s_dvd_next[l]  = (CW'(mag) << FRAC_BITS) + CW'(in_root);
            s_ovf_next[l]  = s_dvd_next[l] >= (s_dvs_next << QW);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_vld_reg <= 1'b0;
        end else if (ce) begin
            s_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s_dvd_reg  <= s_dvd_next;
            s_dvs_reg  <= s_dvs_next;
            s_ovf_reg  <= s_ovf_next;
            s_neg_reg  <= s_neg_next;
            s_zero_reg <= (in_root == '0);
            s_br_reg   <= in_side.br;
            s_big_reg  <= s_big_next;
        end
    end

    for (genvar t = 0; t < QW; t++) begin : g_st
        localparam int BIT = QW - 1 - t;
        logic               vld_src, zero_src;
        logic [2:0][CW-1:0] rem_src, rem_next;
        logic [2:0][QW-1:0] q_src, q_next;
        logic [CW-1:0]      dvs_src, sh;
        logic [2:0]         ovf_src, neg_src;
        branch_t            br_src;
        logic [RW-1:0]      big_src;

        if (t == 0) begin : g_first
            assign vld_src  = s_vld_reg;
            assign rem_src  = s_dvd_reg;
            assign q_src    = '0;
            assign dvs_src  = s_dvs_reg;
            assign ovf_src  = s_ovf_reg;
            assign neg_src  = s_neg_reg;
            assign zero_src = s_zero_reg;
            assign br_src   = s_br_reg;
            assign big_src  = s_big_reg;
        end else begin : g_next
            assign vld_src  = vld_reg[t-1];
            assign rem_src  = rem_reg[t-1];
            assign q_src    = q_reg[t-1];
            assign dvs_src  = dvs_reg[t-1];
            assign ovf_src  = ovf_reg[t-1];
            assign neg_src  = neg_reg[t-1];
            assign zero_src = zero_reg[t-1];
            assign br_src   = br_reg[t-1];
            assign big_src  = big_reg[t-1];
        end

        assign sh = dvs_src << BIT;

        always_comb begin
            rem_next = rem_src;
            q_next   = q_src;
            for (int l = 0; l < 3; l++) begin
                if (rem_src[l] >= sh) begin
                    rem_next[l]    = rem_src[l] - sh;
                    q_next[l][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[t] <= 1'b0;
            end else if (ce) begin
                vld_reg[t] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[t]  <= rem_next;
                q_reg[t]    <= q_next;
                dvs_reg[t]  <= dvs_src;
                ovf_reg[t]  <= ovf_src;
                neg_reg[t]  <= neg_src;
                zero_reg[t] <= zero_src;
                br_reg[t]   <= br_src;
                big_reg[t]  <= big_src;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_br    = br_reg[QW-1];
    assign out_big   = big_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_ovf   = ovf_reg[QW-1];
    assign out_neg   = neg_reg[QW-1];
    assign out_zero  = zero_reg[QW-1];

endmodule
`default_nettype wire

FILE: sv/rmq_back.sv
// Output stage: signs, saturation to plus or minus one, component placement.
// Depends on rmq_pkg.
`default_nettype none
module rmq_back
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int RW        = 17
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         ce,
    input  wire logic                         in_valid,
    input  wire branch_t                      in_br,
    input  wire logic [RW-1:0]                in_big,
    input  wire logic [2:0][FRAC_BITS:0]      in_q,
    input  wire logic [2:0]                   in_ovf,
    input  wire logic [2:0]                   in_neg,
    input  wire logic                         in_zero,
    output logic                              out_valid,
    output logic [N_OUT*DATA_W-1:0]           out_data
);

    localparam int MW = ((RW > FRAC_BITS + 1) ? RW : FRAC_BITS + 1) + 1;

    logic                        vld_reg;
    logic [N_OUT*DATA_W-1:0]     data_reg, data_next;
    logic [MW-1:0]               one_c;

    assign one_c = MW'(1) << FRAC_BITS;

    always_comb begin
        logic [1:0]                ln;
        logic [MW-1:0]             mag;
        logic signed [MW:0]        val;
        data_next = '0;
        for (int j = 0; j < N_OUT; j++) begin
            ln = (2'(j) > in_br) ? 2'(j - 1) : 2'(j);
            if (2'(j) == in_br) begin
                mag = (MW'(in_big) > one_c) ? one_c : MW'(in_big);
                val = $signed({1'b0, mag});
            end else begin
                if (in_zero) begin
                    mag = '0;
                end else if (in_ovf[ln] || MW'(in_q[ln]) > one_c) begin
                    mag = one_c;
                end else begin
                    mag = MW'(in_q[ln]);
                end
                val = in_neg[ln] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            data_next[j*DATA_W +: DATA_W] = DATA_W'(val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

FILE: sv/rmq_checker.sv
// Port-level checks for rotation_matrix_to_quaternion, attached by bind.
// Depends on rmq_pkg.
`default_nettype none
module rmq_checker
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tready,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [N_OUT*DATA_W-1:0]  m_tdata
);

    logic in_range;

    always_comb begin
        logic signed [DATA_W:0] v;
        logic signed [DATA_W:0] lim;
        in_range = 1'b1;
        lim      = (DATA_W+1)'(1) <<< ((FRAC_BITS > 14) ? 0 : FRAC_BITS);
        for (int j = 0; j < N_OUT; j++) begin
            v = $signed({m_tdata[j*DATA_W+DATA_W-1], m_tdata[j*DATA_W +: DATA_W]});
            if (v > lim || v < -lim) begin
                in_range = 1'b0;
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && FRAC_BITS <= 14 |-> in_range)
        else $error("component outside plus or minus one");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
